// ===== sv/pfps_pkg.sv =====
// shared constants, types and helpers for the polygon face plane setup pipeline
`timescale 1ns / 1ps
package pfps_pkg;

	localparam int COORD_W   = 32;
	localparam int EDGE_W    = COORD_W + 1;
	localparam int PROD_W    = 2 * EDGE_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int MAG_W     = PROD_W;
	localparam int NORM_BITS = 30;
	localparam int SUM_W     = 2 * NORM_BITS + 2;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int NUM_W     = 2 * NORM_BITS + 1;
	localparam int QUOT_W    = NORM_BITS + 1;
	localparam int LEN_W     = 7;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// per-face data that rides along the root and divide stages
	typedef struct packed {
		logic [2:0][NORM_BITS-1:0] mag;
		logic [2:0]                neg;
		logic [2:0][COORD_W-1:0]   v0;
		logic                      zero;
	} pfps_ctx_t;

	// bit length of a magnitude
	function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] x);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (x[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== sv/polygon_face_plane_setup.sv =====
// top level: face normal, unit normal, plane offset and projection axes
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, v0_* v1_* v2_*        | request in
//  out     | out_valid, out_ready, unit_n*, plane_offset,| result out
//          | gamma/alpha/beta_axis, degenerate         |
//
// one face per cycle unless out_ready stalls: 8 setup stages (edges, cross
// product, magnitude, bit length, scale, squares, sum), 31 square-root stages, one
// numerator stage, 31 divide stages (three lanes), a multiply and a final stage.
// arst_n clears only the valid bits; data registers are not reset.
// a stall holds only the full stages behind it; bubbles close up, so input
// keeps flowing while a result waits at the output register.
`timescale 1ns / 1ps
module polygon_face_plane_setup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] v0_x,
	input  logic signed [31:0] v0_y,
	input  logic signed [31:0] v0_z,
	input  logic signed [31:0] v1_x,
	input  logic signed [31:0] v1_y,
	input  logic signed [31:0] v1_z,
	input  logic signed [31:0] v2_x,
	input  logic signed [31:0] v2_y,
	input  logic signed [31:0] v2_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] unit_nx,
	output logic signed [31:0] unit_ny,
	output logic signed [31:0] unit_nz,
	output logic signed [31:0] plane_offset,
	output logic [1:0]         gamma_axis,
	output logic [1:0]         alpha_axis,
	output logic [1:0]         beta_axis,
	output logic               degenerate
);

	localparam int NB = pfps_pkg::NORM_BITS;
	localparam int RW = pfps_pkg::ROOT_W;
	localparam int QW = pfps_pkg::QUOT_W;
	localparam int SQ_BASE = 8;
	localparam int PRE = SQ_BASE + RW;
	localparam int DV_BASE = PRE + 1;
	localparam int MUL = DV_BASE + QW;
	localparam int OUT = MUL + 1;
	localparam int NS = OUT + 1;

	logic [NS-1:0] vld;
	logic [NS-1:0] adv;

	// stage k loads when it is empty or its content moves on
	assign adv[NS-1] = !vld[NS-1] || out_ready;
	for (genvar k = 0; k < NS - 1; k++) begin : g_adv
		assign adv[k] = !vld[k] || adv[k+1];
	end

	for (genvar k = 0; k < NS; k++) begin : g_vld
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld[k] <= 1'b0;
				end else if (adv[k]) begin
					vld[k] <= in_valid;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld[k] <= 1'b0;
				end else if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld[OUT];

	// stage 1: edge vectors
	logic signed [pfps_pkg::EDGE_W-1:0] d1_s1 [3];
	logic signed [pfps_pkg::EDGE_W-1:0] d2_s1 [3];
	logic [2:0][31:0]                   v0_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			d1_s1[0] <= 33'(v1_x) - 33'(v0_x);
			d1_s1[1] <= 33'(v1_y) - 33'(v0_y);
			d1_s1[2] <= 33'(v1_z) - 33'(v0_z);
			d2_s1[0] <= 33'(v2_x) - 33'(v1_x);
			d2_s1[1] <= 33'(v2_y) - 33'(v1_y);
			d2_s1[2] <= 33'(v2_z) - 33'(v1_z);
			v0_s1    <= {v0_z, v0_y, v0_x};
		end
	end

	// stage 2: cross product partial products
	logic signed [pfps_pkg::PROD_W-1:0] p_s2 [3];
	logic signed [pfps_pkg::PROD_W-1:0] q_s2 [3];
	logic [2:0][31:0]                   v0_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p_s2[0] <= 66'(d1_s1[1]) * 66'(d2_s1[2]);
			q_s2[0] <= 66'(d2_s1[1]) * 66'(d1_s1[2]);
			p_s2[1] <= 66'(d1_s1[2]) * 66'(d2_s1[0]);
			q_s2[1] <= 66'(d2_s1[2]) * 66'(d1_s1[0]);
			p_s2[2] <= 66'(d1_s1[0]) * 66'(d2_s1[1]);
			q_s2[2] <= 66'(d2_s1[0]) * 66'(d1_s1[1]);
			v0_s2   <= v0_s1;
		end
	end

	// stage 3: exact normal
	logic signed [pfps_pkg::CROSS_W-1:0] n_s3 [3];
	logic [2:0][31:0]                    v0_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int j = 0; j < 3; j++) begin
				n_s3[j] <= 67'(p_s2[j]) - 67'(q_s2[j]);
			end
			v0_s3 <= v0_s2;
		end
	end

	// stage 4: sign and magnitude
	logic [pfps_pkg::MAG_W-1:0] mag_s4 [3];
	pfps_pkg::pfps_ctx_t        ctx_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int j = 0; j < 3; j++) begin
				mag_s4[j]     <= n_s3[j][66] ? 66'(-n_s3[j]) : n_s3[j][65:0];
				ctx_s4.neg[j] <= n_s3[j][66];
			end
			ctx_s4.mag  <= '0;
			ctx_s4.v0   <= v0_s3;
			ctx_s4.zero <= (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
		end
	end

	// stage 5: bit length of the largest component
	logic [pfps_pkg::MAG_W-1:0] mag_s5 [3];
	logic [pfps_pkg::LEN_W-1:0] len_s5;
	pfps_pkg::pfps_ctx_t        ctx_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			mag_s5 <= mag_s4;
			len_s5 <= pfps_pkg::bit_len(mag_s4[0] | mag_s4[1] | mag_s4[2]);
			ctx_s5 <= ctx_s4;
		end
	end

	// stage 6: scale so the largest lies in [2^29, 2^30)
	pfps_pkg::pfps_ctx_t ctx_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			ctx_s6.neg  <= ctx_s5.neg;
			ctx_s6.v0   <= ctx_s5.v0;
			ctx_s6.zero <= ctx_s5.zero;
			for (int j = 0; j < 3; j++) begin
				ctx_s6.mag[j] <= NB'({mag_s5[j], NB'(0)} >> len_s5);
			end
		end
	end

	// stage 7: squares
	logic [2*NB-1:0]     sq_s7 [3];
	pfps_pkg::pfps_ctx_t ctx_s7;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			for (int j = 0; j < 3; j++) begin
				sq_s7[j] <= (2*NB)'(ctx_s6.mag[j]) * (2*NB)'(ctx_s6.mag[j]);
			end
			ctx_s7 <= ctx_s6;
		end
	end

	// stage 8 and square root: one root bit per stage
	logic [pfps_pkg::SUM_W-1:0] sq_x_sk   [0:RW];
	logic [RW+1:0]              sq_rem_sk [0:RW];
	logic [RW-1:0]              sq_root_sk[0:RW];
	pfps_pkg::pfps_ctx_t        sq_ctx_sk [0:RW];

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			sq_x_sk[0]    <= pfps_pkg::SUM_W'(sq_s7[0]) + pfps_pkg::SUM_W'(sq_s7[1])
				+ pfps_pkg::SUM_W'(sq_s7[2]);
			sq_rem_sk[0]  <= '0;
			sq_root_sk[0] <= '0;
			sq_ctx_sk[0]  <= ctx_s7;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+3:0] rt;
		logic [RW+3:0] tt;
		logic          ge;

		assign rt = {sq_rem_sk[k], sq_x_sk[k][pfps_pkg::SUM_W-1-2*k -: 2]};
		assign tt = {2'b00, sq_root_sk[k], 2'b01};
		assign ge = rt >= tt;

		always_ff @(posedge clk) begin
			if (adv[SQ_BASE+k]) begin
				sq_x_sk[k+1]    <= sq_x_sk[k];
				sq_rem_sk[k+1]  <= ge ? (RW+2)'(rt - tt) : rt[RW+1:0];
				sq_root_sk[k+1] <= {sq_root_sk[k][RW-2:0], ge};
				sq_ctx_sk[k+1]  <= sq_ctx_sk[k];
			end
		end
	end

	// numerator stage and restoring divide, one quotient bit per stage per lane
	logic [QW-1:0]       dv_rem_sk [0:QW][3];
	logic [QW-1:0]       dv_low_sk [0:QW][3];
	logic [QW-1:0]       dv_quo_sk [0:QW][3];
	logic [RW-1:0]       dv_len_sk [0:QW];
	pfps_pkg::pfps_ctx_t dv_ctx_sk [0:QW];
	logic [pfps_pkg::NUM_W-1:0] num_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_c[j] = {1'b0, sq_ctx_sk[RW].mag[j], NB'(0)}
				+ pfps_pkg::NUM_W'(sq_root_sk[RW] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[PRE]) begin
			for (int j = 0; j < 3; j++) begin
				dv_rem_sk[0][j] <= QW'(num_c[j][pfps_pkg::NUM_W-1:QW]);
				dv_low_sk[0][j] <= num_c[j][QW-1:0];
				dv_quo_sk[0][j] <= '0;
			end
			dv_len_sk[0] <= sq_root_sk[RW];
			dv_ctx_sk[0] <= sq_ctx_sk[RW];
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [QW:0] t   [3];
		logic [2:0]  ge;

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				t[j]  = {dv_rem_sk[i][j], dv_low_sk[i][j][QW-1-i]};
				ge[j] = t[j] >= {1'b0, dv_len_sk[i]};
			end
		end

		always_ff @(posedge clk) begin
			if (adv[DV_BASE+i]) begin
				for (int j = 0; j < 3; j++) begin
					dv_rem_sk[i+1][j] <= ge[j] ? QW'(t[j] - {1'b0, dv_len_sk[i]})
						: t[j][QW-1:0];
					dv_low_sk[i+1][j] <= dv_low_sk[i][j];
					dv_quo_sk[i+1][j] <= {dv_quo_sk[i][j][QW-2:0], ge[j]};
				end
				dv_len_sk[i+1] <= dv_len_sk[i];
				dv_ctx_sk[i+1] <= dv_ctx_sk[i];
			end
		end
	end

	// multiply stage: signed unit components times vertex 0
	logic signed [31:0] u_c     [3];
	logic signed [31:0] u_sm    [3];
	logic signed [63:0] prod_sm [3];
	logic [QW-1:0]      m_sm    [3];
	logic               zero_sm;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			u_c[j] = dv_ctx_sk[QW].neg[j] ? -$signed(32'(dv_quo_sk[QW][j]))
				: $signed(32'(dv_quo_sk[QW][j]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[MUL]) begin
			for (int j = 0; j < 3; j++) begin
				u_sm[j]    <= u_c[j];
				m_sm[j]    <= dv_quo_sk[QW][j];
				prod_sm[j] <= 64'(u_c[j]) * 64'($signed(dv_ctx_sk[QW].v0[j]));
			end
			zero_sm <= dv_ctx_sk[QW].zero;
		end
	end

	// final stage: offset rounding, saturation, axis choice and zeroed outputs for a degenerate face
	logic signed [63:0] dot_c;
	logic signed [63:0] wr_c;
	logic signed [33:0] w_c;
	logic signed [31:0] wsat_c;
	logic [1:0]         gam_c;
	logic [1:0]         alp_c;
	logic [1:0]         bet_c;

	always_comb begin
		dot_c = prod_sm[0] + prod_sm[1] + prod_sm[2];
		wr_c  = -dot_c + 64'(1 << (NB - 1));
		w_c   = 34'(wr_c >>> NB);
		if (w_c > 34'sh0_7fff_ffff) begin
			wsat_c = 32'sh7fff_ffff;
		end else if (w_c < -34'sh0_8000_0000) begin
			wsat_c = 32'sh8000_0000;
		end else begin
			wsat_c = w_c[31:0];
		end
		priority if (m_sm[0] > m_sm[1] && m_sm[0] > m_sm[2]) begin
			gam_c = pfps_pkg::AXIS_X;
			alp_c = pfps_pkg::AXIS_Y;
			bet_c = pfps_pkg::AXIS_Z;
		end else if (m_sm[1] > m_sm[2]) begin
			gam_c = pfps_pkg::AXIS_Y;
			alp_c = pfps_pkg::AXIS_Z;
			bet_c = pfps_pkg::AXIS_X;
		end else begin
			gam_c = pfps_pkg::AXIS_Z;
			alp_c = pfps_pkg::AXIS_X;
			bet_c = pfps_pkg::AXIS_Y;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[OUT]) begin
			if (zero_sm) begin
				unit_nx      <= '0;
				unit_ny      <= '0;
				unit_nz      <= '0;
				plane_offset <= '0;
				gamma_axis   <= pfps_pkg::AXIS_X;
				alpha_axis   <= pfps_pkg::AXIS_X;
				beta_axis    <= pfps_pkg::AXIS_X;
				degenerate   <= 1'b1;
			end else begin
				unit_nx      <= u_sm[0];
				unit_ny      <= u_sm[1];
				unit_nz      <= u_sm[2];
				plane_offset <= wsat_c;
				gamma_axis   <= gam_c;
				alpha_axis   <= alp_c;
				beta_axis    <= bet_c;
				degenerate   <= 1'b0;
			end
		end
	end

endmodule

// ===== test/tb_polygon_face_plane_setup.sv =====
// testbench for polygon_face_plane_setup: random and directed faces checked by a scoreboard
`timescale 1ns / 1ps

typedef struct {
	logic signed [31:0] nx, ny, nz, w;
	logic [1:0]         g, a, b;
	logic               degen;
} plane_t;

class plane_scoreboard;
	plane_t pending_planes[$];
	int     errors = 0;

	static function logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// works out the plane of one face and queues it
	function void note_face(logic signed [31:0] vt[9]);
		longint d1[3], d2[3], v0[3], u[3], dotp, wv, ax, ay, az;
		logic signed [67:0] n[3];
		logic [66:0] mg[3], orv;
		logic [63:0] a[3], sum2, len, m;
		int L;
		plane_t p;
		for (int j = 0; j < 3; j++) begin
			v0[j] = longint'(vt[j]);
			d1[j] = longint'(vt[3+j]) - longint'(vt[j]);
			d2[j] = longint'(vt[6+j]) - longint'(vt[3+j]);
		end
		n[0] = 68'(d1[1]) * 68'(d2[2]) - 68'(d2[1]) * 68'(d1[2]);
		n[1] = 68'(d1[2]) * 68'(d2[0]) - 68'(d2[2]) * 68'(d1[0]);
		n[2] = 68'(d1[0]) * 68'(d2[1]) - 68'(d2[0]) * 68'(d1[1]);
		orv = 0;
		for (int j = 0; j < 3; j++) begin
			mg[j] = n[j] < 0 ? 67'(-n[j]) : 67'(n[j]);
			orv |= mg[j];
		end
		p = '{default: 0};
		if (orv == 0) begin
			p.degen = 1;
			pending_planes.push_back(p);
			return;
		end
		L = 0;
		for (int i = 0; i < 67; i++) if (orv[i]) L = i + 1;
		sum2 = 0;
		for (int j = 0; j < 3; j++) begin
			a[j] = L > 30 ? 64'(mg[j] >> (L - 30)) : 64'(mg[j] << (30 - L));
			sum2 += a[j] * a[j];
		end
		len = root_floor(sum2);
		dotp = 0;
		for (int j = 0; j < 3; j++) begin
			m = ((a[j] << 30) + (len >> 1)) / len;
			u[j] = n[j] < 0 ? -longint'(m) : longint'(m);
			dotp += u[j] * v0[j];
		end
		wv = (-dotp + (longint'(1) << 29)) >>> 30;
		if (wv > 64'sd2147483647) wv = 64'sd2147483647;
		if (wv < -64'sd2147483648) wv = -64'sd2147483648;
		ax = u[0] < 0 ? -u[0] : u[0];
		ay = u[1] < 0 ? -u[1] : u[1];
		az = u[2] < 0 ? -u[2] : u[2];
		if (ax > ay && ax > az) p.g = pfps_pkg::AXIS_X;
		else p.g = ay > az ? pfps_pkg::AXIS_Y : pfps_pkg::AXIS_Z;
		p.a = p.g == pfps_pkg::AXIS_Z ? pfps_pkg::AXIS_X : p.g + 2'd1;
		p.b = p.a == pfps_pkg::AXIS_Z ? pfps_pkg::AXIS_X : p.a + 2'd1;
		p.nx = 32'(u[0]);
		p.ny = 32'(u[1]);
		p.nz = 32'(u[2]);
		p.w = 32'(wv);
		pending_planes.push_back(p);
	endfunction

	function void check_plane(plane_t got);
		plane_t e;
		if (pending_planes.size() == 0) begin
			$display("%0t: unexpected result nx=%0d ny=%0d nz=%0d w=%0d", $time,
				got.nx, got.ny, got.nz, got.w);
			errors++;
			return;
		end
		e = pending_planes.pop_front();
		if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz || got.w !== e.w
			|| got.g !== e.g || got.a !== e.a || got.b !== e.b
			|| got.degen !== e.degen) begin
			$display("%0t: mismatch expected nx=%0d ny=%0d nz=%0d w=%0d g=%0d a=%0d b=%0d dg=%0d",
				$time, e.nx, e.ny, e.nz, e.w, e.g, e.a, e.b, e.degen);
			$display("%0t:            actual nx=%0d ny=%0d nz=%0d w=%0d g=%0d a=%0d b=%0d dg=%0d",
				$time, got.nx, got.ny, got.nz, got.w, got.g, got.a, got.b, got.degen);
			errors++;
		end
	endfunction
endclass

module tb_polygon_face_plane_setup;
	localparam int RANDOM_FACES = 1430;
	localparam logic signed [31:0] CMAX = 32'sh7fffffff;
	localparam logic signed [31:0] CMIN = 32'sh80000000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [31:0] vt[9];
	logic signed [31:0] unit_nx, unit_ny, unit_nz, plane_offset;
	logic [1:0] gamma_axis, alpha_axis, beta_axis;
	logic degenerate;
	plane_scoreboard sb = new();
	bit calm = 0;
	bit hold_done = 0;
	int hold_off = 0;
	int faces_sent = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	polygon_face_plane_setup dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.v0_x(vt[0]), .v0_y(vt[1]), .v0_z(vt[2]),
		.v1_x(vt[3]), .v1_y(vt[4]), .v1_z(vt[5]),
		.v2_x(vt[6]), .v2_y(vt[7]), .v2_z(vt[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.unit_nx(unit_nx), .unit_ny(unit_ny), .unit_nz(unit_nz),
		.plane_offset(plane_offset), .gamma_axis(gamma_axis),
		.alpha_axis(alpha_axis), .beta_axis(beta_axis), .degenerate(degenerate)
	);

	// offers one face, called at a falling edge, returns at a falling edge
	task automatic send_face(logic signed [31:0] f[9]);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid = 0;
			@(negedge clk);
		end
		vt = f;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_face(vt);
		faces_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic send_tri(logic signed [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
		logic signed [31:0] f[9];
		f = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
		send_face(f);
	endtask

	function automatic logic signed [31:0] rnd_coord(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(2000)) - 1000;
			default: return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
		endcase
	endfunction

	// receiver, with one long hold-off once the pipeline is busy
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else if (!hold_done && faces_sent >= 300) begin
			hold_done <= 1;
			hold_off <= 400;
			out_ready <= 0;
		end else begin
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_plane('{unit_nx, unit_ny, unit_nz, plane_offset,
				gamma_axis, alpha_axis, beta_axis, degenerate});
	end

	initial begin
		logic signed [31:0] f[9];
		int kind, waited;
		for (int i = 0; i < 9; i++) vt[i] = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// zero normal: identical and collinear vertices
		send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_tri(5, 7, 9, 6, 8, 10, 8, 10, 12);
		send_tri(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		// axis normals
		send_tri(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0);
		send_tri(0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000);
		send_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 32'h10000);
		send_tri(3, 4, 5, 3, 4, 6, 4, 4, 6);
		// ties in magnitude
		send_tri(0, 0, 0, 1, -1, 0, 1, -1, 1);
		send_tri(0, 0, 0, 1, 0, -1, 1, 1, -1);
		send_tri(0, 0, 0, 0, 1, -1, 1, 1, -1);
		send_tri(7, 7, 7, 8, 6, 7, 7, 6, 8);
		// offset saturating both ways
		send_tri(CMIN, CMIN + 1, CMIN, CMIN + 1, CMIN, CMIN, CMIN, CMIN, CMIN + 1);
		send_tri(CMAX, CMAX - 1, CMAX, CMAX - 1, CMAX, CMAX, CMAX, CMAX, CMAX - 1);
		// extreme coordinates, largest cross product
		send_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
		send_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN);
		send_tri(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);
		send_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1);
		send_tri(CMAX, 0, CMIN, 0, CMAX, 0, CMIN, 0, CMAX);

		for (int k = 0; k < RANDOM_FACES; k++) begin
			calm = (k >= 700 && k < 900);
			kind = $urandom_range(2);
			for (int i = 0; i < 9; i++) f[i] = rnd_coord(kind);
			case ($urandom_range(9))
				0: for (int i = 0; i < 3; i++) f[6+i] = f[3+i] + (f[3+i] - f[i]);
				1: for (int i = 0; i < 3; i++) f[3+i] = f[i] + $signed($urandom_range(4)) - 2;
				default: ;
			endcase
			send_face(f);
		end
		calm = 0;

		waited = 0;
		while (sb.pending_planes.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (150) @(negedge clk);
		if (sb.errors == 0 && sb.pending_planes.size() == 0)
			$display("polygon_face_plane_setup regression: pass");
		else
			$display("polygon_face_plane_setup regression: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("polygon_face_plane_setup regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/pfps_pkg.sv
sv/polygon_face_plane_setup.sv
test/tb_polygon_face_plane_setup.sv
